// ===== rtl/core/csd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the circular server dispatcher.
// Holds the transfer payload types, field widths and shared constants; no dependencies.
package csd_pkg;

  localparam int CFG_W           = 5;
  localparam int TIME_W          = 32;
  localparam int BUSY_W          = 33;
  localparam int CNT_W           = 32;
  localparam int SID_W           = 4;
  localparam int MASK_W          = 16;
  localparam int MAX_SERVERS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_W-1:0] NUM_SERVERS_RST = CFG_W'(16);

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] duration;
    logic              is_last;
  } csd_in_t;

  typedef struct packed {
    logic              accepted;
    logic [SID_W-1:0]  server_id;
    logic              summary_valid;
    logic [MASK_W-1:0] busiest_mask;
    logic [CNT_W-1:0]  top_count;
  } csd_out_t;

  // A request as the back end sees it, with the clamped server count attached.
  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] duration;
    logic              is_last;
    logic [CFG_W-1:0]  n_srv;
  } csd_item_t;

endpackage

// ===== rtl/core/csd_front.sv =====
`timescale 1ns / 1ps
// Front end of the circular server dispatcher: configuration register and request intake.
// Depends on csd_pkg; feeds csd_queue.
module csd_front #(
  parameter int MAX_SERVERS = csd_pkg::MAX_SERVERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [csd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  csd_pkg::csd_in_t          in_data_i,
  input  logic                      full_i,
  output logic                      push_o,
  output csd_pkg::csd_item_t        item_o
);
  import csd_pkg::*;

  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_srv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= NUM_SERVERS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // A count of zero means one server; a count above the built size saturates.
  always_comb begin
    if (cfg_q == '0) begin
      n_srv = CFG_W'(1);
    end else if (int'(cfg_q) > MAX_SERVERS) begin
      n_srv = CFG_W'(MAX_SERVERS);
    end else begin
      n_srv = cfg_q;
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.arrival_time = in_data_i.arrival_time;
    item_o.duration     = in_data_i.duration;
    item_o.is_last      = in_data_i.is_last;
    item_o.n_srv        = n_srv;
  end

endmodule

// ===== rtl/core/csd_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front and back ends of the circular server dispatcher.
// Depends on csd_pkg for the item type and depth.
module csd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csd_pkg::csd_item_t  item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output csd_pkg::csd_item_t  item_o
);
  import csd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  csd_item_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q;
  logic [PW-1:0]   rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/csd_back.sv =====
`timescale 1ns / 1ps
// Back end of the circular server dispatcher: server state memories, the free-server scan,
// the busiest-server summary and the output register. Depends on csd_pkg.
module csd_back #(
  parameter int MAX_SERVERS = csd_pkg::MAX_SERVERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  csd_pkg::csd_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csd_pkg::csd_out_t   out_data_o
);
  import csd_pkg::*;

  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e             state_q;
  csd_item_t          item_q;
  logic [CFG_W-1:0]   ptr_q;
  logic [CFG_W-1:0]   base_q;
  logic [CFG_W-1:0]   iss_idx_q;
  logic [CFG_W-1:0]   iss_cnt_q;
  logic [CFG_W-1:0]   chk_cnt_q;
  logic               inf_q;
  logic [CFG_W-1:0]   inf_idx_q;
  logic               acc_q;
  logic [SID_W-1:0]   sid_q;
  logic               sumv_q;
  logic [MASK_W-1:0]  mask_q;
  logic [CNT_W-1:0]   top_q;
  csd_out_t           out_q;
  logic               out_valid_q;

  logic [BUSY_W-1:0]      busy_mem [MAX_SERVERS];
  logic [CNT_W-1:0]       cnt_mem  [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_q;
  logic [BUSY_W-1:0]      busy_rd_q;
  logic [CNT_W-1:0]       cnt_rd_q;
  logic                   rd_vld_q;

  logic [BUSY_W-1:0]  busy_eff;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   cnt_inc;
  logic [BUSY_W-1:0]  busy_new;
  logic [CFG_W-1:0]   ptr0;
  logic [CFG_W-1:0]   ptr_next;
  logic [CFG_W-1:0]   iss_next;
  logic               hit;
  logic               last_chk;
  logic               scan_end;
  logic               rd_en;
  logic               we;
  logic               clr;
  logic               out_free;
  logic [MASK_W-1:0]  bit_sel;
  logic [MASK_W-1:0]  mask_nx;
  logic [CNT_W-1:0]   top_nx;

  assign busy_eff = rd_vld_q ? busy_rd_q : '0;
  assign cnt_eff  = rd_vld_q ? cnt_rd_q : '0;
  assign cnt_inc  = (cnt_eff == '1) ? cnt_eff : cnt_eff + CNT_W'(1);
  assign busy_new = {1'b0, item_q.arrival_time} + {1'b0, item_q.duration};
  assign ptr0     = (ptr_q >= q_item_i.n_srv) ? '0 : ptr_q;
  assign ptr_next = (base_q + CFG_W'(1) == item_q.n_srv) ? '0 : base_q + CFG_W'(1);
  assign last_chk = (chk_cnt_q == item_q.n_srv - CFG_W'(1));
  assign hit      = inf_q && (busy_eff <= {1'b0, item_q.arrival_time});
  assign scan_end = inf_q && (hit || last_chk);
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign we       = (state_q == ST_SCAN) && hit;
  assign clr      = (state_q == ST_SUM) && inf_q && last_chk;
  assign bit_sel  = MASK_W'(1) << inf_idx_q;

  always_comb begin
    rd_en    = 1'b0;
    iss_next = iss_idx_q + CFG_W'(1);
    unique case (state_q)
      ST_SCAN: begin
        rd_en = !scan_end && (iss_cnt_q < item_q.n_srv);
        if (iss_next == item_q.n_srv) begin
          iss_next = '0;
        end
      end
      ST_SUM: begin
        rd_en = !(inf_q && last_chk) && (iss_cnt_q < item_q.n_srv);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    top_nx  = top_q;
    mask_nx = mask_q;
    if (inf_q) begin
      if (cnt_eff > top_q) begin
        top_nx  = cnt_eff;
        mask_nx = bit_sel;
      end else if (cnt_eff == top_q) begin
        mask_nx = mask_q | bit_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      busy_mem[SW'(inf_idx_q)] <= busy_new;
      cnt_mem[SW'(inf_idx_q)]  <= cnt_inc;
    end
    if (rd_en) begin
      busy_rd_q <= busy_mem[SW'(iss_idx_q)];
      cnt_rd_q  <= cnt_mem[SW'(iss_idx_q)];
      rd_vld_q  <= vld_q[SW'(iss_idx_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[SW'(inf_idx_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          item_q    <= q_item_i;
          base_q    <= ptr0;
          iss_idx_q <= ptr0;
          iss_cnt_q <= '0;
          chk_cnt_q <= '0;
          acc_q     <= 1'b0;
          sid_q     <= '0;
          sumv_q    <= 1'b0;
          mask_q    <= '0;
          top_q     <= '0;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (hit) begin
            acc_q <= 1'b1;
            sid_q <= SID_W'(inf_idx_q);
          end
          iss_idx_q <= '0;
          iss_cnt_q <= '0;
          chk_cnt_q <= '0;
        end else begin
          if (inf_q) begin
            chk_cnt_q <= chk_cnt_q + CFG_W'(1);
          end
          if (rd_en) begin
            inf_idx_q <= iss_idx_q;
            iss_idx_q <= iss_next;
            iss_cnt_q <= iss_cnt_q + CFG_W'(1);
          end
        end
      end
      ST_SUM: begin
        top_q  <= top_nx;
        mask_q <= mask_nx;
        if (clr) begin
          sumv_q <= 1'b1;
        end else begin
          if (inf_q) begin
            chk_cnt_q <= chk_cnt_q + CFG_W'(1);
          end
          if (rd_en) begin
            inf_idx_q <= iss_idx_q;
            iss_idx_q <= iss_next;
            iss_cnt_q <= iss_cnt_q + CFG_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.accepted      <= acc_q;
          out_q.server_id     <= sid_q;
          out_q.summary_valid <= sumv_q;
          out_q.busiest_mask  <= mask_q;
          out_q.top_count     <= top_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      inf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          inf_q <= 1'b0;
          if (q_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            inf_q <= 1'b0;
            ptr_q <= ptr_next;
            state_q <= item_q.is_last ? ST_SUM : ST_DONE;
          end else begin
            inf_q <= rd_en;
          end
        end
        ST_SUM: begin
          if (clr) begin
            inf_q   <= 1'b0;
            ptr_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            inf_q <= rd_en;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/circular_server_dispatcher.sv =====
`timescale 1ns / 1ps
// Circular server dispatcher: assigns each request to the first free server on a ring,
// counts served requests per server and reports the busiest servers at the end of a batch.
// The input channel carries csd_in_t with valid and stall; the output channel carries
// csd_out_t with valid and stall. The configuration channel writes the server count,
// with valid and ready; it is always ready, and a write applies to requests transferred
// after it, so the user must write it only while no request is in flight; the block does
// not enforce this. Every request gives exactly one result transfer, in request order.
// From leaving the queue to its result register being loaded, a request goes through a
// scan of the server state memories over at most n entries, n being the server count in
// use, one entry per cycle; the scan stops at the first free server. The back end goes
// back to idle after loading the result before it takes the next request. A request
// marked last adds a summary pass over the served counts, after which all server state
// is cleared.
// A two-entry queue lets the input side keep transferring while the back end works.
// Reset clears all server state, the start pointer and the queue, and sets the server
// count to 16. While the receiver stalls, the result register holds its transfer, the
// back end waits with the next finished result, and the input stalls once the queue fills.
module circular_server_dispatcher #(
  parameter int MAX_SERVERS = csd_pkg::MAX_SERVERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [csd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  csd_pkg::csd_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output csd_pkg::csd_out_t         out_data_o
);
  import csd_pkg::*;

  logic      push;
  logic      full;
  logic      pop;
  logic      q_valid;
  csd_item_t push_item;
  csd_item_t q_item;

  csd_front #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  csd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  csd_back #(
    .MAX_SERVERS(MAX_SERVERS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
